@@ hw/rtl/wtm_pkg.sv @@
// Shared constants for the windowed throughput meter: command codes and field widths.
`default_nettype none
package wtm_pkg;

    // Command codes carried in s_axis_tuser
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_REPORT = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;
    localparam logic [1:0] CMD_STOP   = 2'd3;

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int ITEM_IN_W = 32;
    localparam int WS_W      = 16;
    localparam int IDX_W     = 48;
    localparam int ITEMS_W   = 48;
    localparam int MS_W      = 40;
    localparam int RATE_W    = 64;

    // Packed stream widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = IDX_W + ITEMS_W + MS_W + RATE_W + ITEMS_W + MS_W + RATE_W;
    localparam int M_TUSER_W = 2;

endpackage
`default_nettype wire

@@ hw/rtl/wtm_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module wtm_div
    import wtm_pkg::*;
#(
    parameter int DVW = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RATE_W-1:0] i_dividend,
    input  wire logic [DVW-1:0]    i_divisor,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [RATE_W-1:0]      o_quotient,
    output logic [DVW-1:0]         o_remainder
);

    localparam int CW = $clog2(RATE_W + 1);

    logic [CW-1:0]     r_cnt;
    logic              r_done;
    logic [RATE_W-1:0] r_quo;     // dividend shifts out the top, quotient shifts in below
    logic [DVW-1:0]    r_rem;
    logic [DVW-1:0]    r_dvs;

    logic [DVW:0] trial;
    logic [DVW:0] diff;
    logic         fits;

    assign trial = {r_rem, r_quo[RATE_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_cnt <= CW'(RATE_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[RATE_W-2:0], fits};
            r_rem <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
        end
    end

    assign o_busy      = (r_cnt != '0);
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

@@ hw/rtl/windowed_throughput_meter_core.sv @@
// Windowed throughput meter: overall and per-window item/time accumulators with rates.
//
// Usage:
//   s_axis carries one command per transfer: tuser = command (tick, report, start,
//   stop); tdata = item_count, force_close, clear. Each accepted command yields
//   exactly one m_axis transfer with status/window_closed in tuser and the held
//   window snapshot plus current overall figures in tdata.
//   The cfg channel writes the window length in reports (0 turns windows off);
//   it is always ready and must only be written while the meter is idle.
// Sequencing:
//   One command at a time. Every command ends in a divide for the overall rate on
//   a shared bit-serial divider (one quotient bit per cycle). A report on a started
//   meter with windows on first divides the report total by the window length; a
//   report that closes a window adds a divide for the window rate.
// Reset: i_rst_n synchronous, active low; clears all accumulators and snapshots,
//   the window length returns to 16.
// Stall: the result sits in an output register; the next command is accepted
//   meanwhile, and its result waits in the last state until the register frees.
`default_nettype none
module windowed_throughput_meter_core
    import wtm_pkg::*;
#(
    parameter int COUNT_BITS = 48,
    parameter int TIME_BITS  = 40
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // cfg write channel: window length in reports
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [WS_W-1:0]      i_cfg_data,
    // command stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // item_count[31:0], force_close, clear, pad
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,   // command[1:0]
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,   // window_index, window_items,
                                                      // window_elapsed_ms, window_rate,
                                                      // overall_items, overall_elapsed_ms,
                                                      // overall_rate
    output logic [M_TUSER_W-1:0]      m_axis_tuser    // status, window_closed
);

    localparam int DVW = (TIME_BITS > WS_W) ? TIME_BITS : WS_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a command
    localparam logic [2:0] ST_EXEC  = 3'd1;  // apply the command to the accumulators
    localparam logic [2:0] ST_MODW  = 3'd2;  // report_total / window length in flight
    localparam logic [2:0] ST_WPREP = 3'd3;  // load window rate divide
    localparam logic [2:0] ST_WDIV  = 3'd4;
    localparam logic [2:0] ST_OPREP = 3'd5;  // load overall rate divide
    localparam logic [2:0] ST_ODIV  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;  // hand result to output register

    logic [2:0] r_state;

    // latched command
    logic [CMD_W-1:0]     r_cmd;
    logic [ITEM_IN_W-1:0] r_items;
    logic                 r_force;
    logic                 r_clr;

    // meter state
    logic [WS_W-1:0]       r_ws;
    logic                  r_started;
    logic                  r_o_run;
    logic                  r_w_run;
    logic [COUNT_BITS-1:0] r_o_cnt;
    logic [TIME_BITS-1:0]  r_o_time;
    logic [COUNT_BITS-1:0] r_w_cnt;
    logic [TIME_BITS-1:0]  r_w_time;
    logic [COUNT_BITS-1:0] r_rtotal;
    logic [COUNT_BITS-1:0] r_lw_cnt;
    logic [TIME_BITS-1:0]  r_lw_time;
    logic [RATE_W-1:0]     r_lw_rate;
    logic [COUNT_BITS-1:0] r_lw_idx;
    logic [RATE_W-1:0]     r_o_rate;
    logic                  r_status;
    logic                  r_closed;

    // divider operands
    logic [RATE_W-1:0] r_dvd;
    logic [DVW-1:0]    r_dvs;
    logic              r_div_start;

    // output register
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TUSER_W-1:0] r_m_tuser;

    // divider results
    logic              div_busy;
    logic              div_done;
    logic [RATE_W-1:0] div_quo;
    logic [DVW-1:0]    div_rem;

    // saturating next values
    logic [COUNT_BITS:0]   sum_o_cnt;
    logic [COUNT_BITS:0]   sum_w_cnt;
    logic [COUNT_BITS-1:0] n_o_cnt;
    logic [COUNT_BITS-1:0] n_w_cnt;
    logic [COUNT_BITS-1:0] n_rtotal;
    logic [TIME_BITS-1:0]  n_o_time;
    logic [TIME_BITS-1:0]  n_w_time;
    logic                  ws_on;
    logic                  mod_start;   // accepted report, meter started, windows on: boundary test

    assign ws_on     = (r_ws != '0);
    assign mod_start = (r_cmd == CMD_REPORT) && r_started && ws_on;
    assign sum_o_cnt = {1'b0, r_o_cnt} + (COUNT_BITS + 1)'(r_items);
    assign sum_w_cnt = {1'b0, r_w_cnt} + (COUNT_BITS + 1)'(r_items);
    assign n_o_cnt   = sum_o_cnt[COUNT_BITS] ? '1 : sum_o_cnt[COUNT_BITS-1:0];
    assign n_w_cnt   = sum_w_cnt[COUNT_BITS] ? '1 : sum_w_cnt[COUNT_BITS-1:0];
    assign n_rtotal  = (&r_rtotal) ? r_rtotal : r_rtotal + COUNT_BITS'(1);
    assign n_o_time  = (&r_o_time) ? r_o_time : r_o_time + TIME_BITS'(1);
    assign n_w_time  = (&r_w_time) ? r_w_time : r_w_time + TIME_BITS'(1);

    // 1000 * x as (x << 10) - (x << 4) - (x << 3); fits in 64 bits for x < 2^54
    function automatic logic [RATE_W-1:0] f_scale(input logic [COUNT_BITS-1:0] x);
        logic [RATE_W-1:0] v;
        v = RATE_W'(x);
        return (v << 10) - (v << 4) - (v << 3);
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= WS_W'(16);
        end else if (i_cfg_valid) begin
            r_ws <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd   <= s_axis_tuser[CMD_W-1:0];
            r_items <= s_axis_tdata[ITEM_IN_W-1:0];
            r_force <= s_axis_tdata[ITEM_IN_W];
            r_clr   <= s_axis_tdata[ITEM_IN_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_o_run     <= 1'b0;
            r_w_run     <= 1'b0;
            r_o_cnt     <= '0;
            r_o_time    <= '0;
            r_w_cnt     <= '0;
            r_w_time    <= '0;
            r_rtotal    <= '0;
            r_lw_cnt    <= '0;
            r_lw_time   <= '0;
            r_lw_rate   <= '0;
            r_lw_idx    <= '0;
            r_o_rate    <= '0;
            r_status    <= 1'b0;
            r_closed    <= 1'b0;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            // divider kicked off from the prep states and from a windowed report
            r_div_start <= (r_state == ST_WPREP) || (r_state == ST_OPREP) ||
                           ((r_state == ST_EXEC) && mod_start);
            if ((r_state == ST_OUT) && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_status <= (r_cmd == CMD_REPORT) && !r_started;
                    r_closed <= 1'b0;
                    r_state  <= mod_start ? ST_MODW : ST_OPREP;
                    case (r_cmd)
                        CMD_TICK: begin
                            if (r_o_run) begin
                                r_o_time <= n_o_time;
                            end
                            if (r_w_run) begin
                                r_w_time <= n_w_time;
                            end
                        end
                        CMD_REPORT: begin
                            if (r_started) begin
                                r_rtotal <= n_rtotal;
                                r_o_cnt  <= n_o_cnt;
                                if (ws_on) begin
                                    // window boundary test: report_total mod window length
                                    r_w_cnt <= n_w_cnt;
                                    r_dvd   <= RATE_W'(n_rtotal);
                                    r_dvs   <= DVW'(r_ws);
                                end
                            end
                        end
                        CMD_START: begin
                            r_started <= 1'b1;
                            r_o_run   <= 1'b1;
                            if (ws_on) begin
                                r_w_run <= 1'b1;
                            end
                            if (r_clr) begin
                                r_o_cnt  <= '0;
                                r_o_time <= '0;
                                if (ws_on) begin
                                    r_w_cnt  <= '0;
                                    r_w_time <= '0;
                                end
                            end
                        end
                        CMD_STOP: begin
                            r_o_run <= 1'b0;
                            r_w_run <= 1'b0;
                            if (r_clr) begin
                                r_o_cnt  <= '0;
                                r_o_time <= '0;
                                r_w_cnt  <= '0;
                                r_w_time <= '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_MODW: begin
                    if (div_done) begin
                        if (r_force || (div_rem == '0)) begin
                            // close: snapshot and restart the window
                            r_lw_cnt  <= r_w_cnt;
                            r_lw_time <= (r_w_time == '0) ? TIME_BITS'(1) : r_w_time;
                            // index = (total - 1) / size, from total / size
                            r_lw_idx  <= (div_rem == '0) ?
                                         div_quo[COUNT_BITS-1:0] - COUNT_BITS'(1) :
                                         div_quo[COUNT_BITS-1:0];
                            r_w_cnt   <= '0;
                            r_w_time  <= '0;
                            r_w_run   <= 1'b1;
                            r_closed  <= 1'b1;
                            r_state   <= ST_WPREP;
                        end else begin
                            r_state <= ST_OPREP;
                        end
                    end
                end
                ST_WPREP: begin
                    r_dvd   <= f_scale(r_lw_cnt);
                    r_dvs   <= DVW'(r_lw_time);
                    r_state <= ST_WDIV;
                end
                ST_WDIV: begin
                    if (div_done) begin
                        r_lw_rate <= div_quo;
                        r_state   <= ST_OPREP;
                    end
                end
                ST_OPREP: begin
                    r_dvd   <= f_scale(r_o_cnt);
                    r_dvs   <= (r_o_time == '0) ? DVW'(1) : DVW'(r_o_time);
                    r_state <= ST_ODIV;
                end
                ST_ODIV: begin
                    if (div_done) begin
                        r_o_rate <= div_quo;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload, loaded together with r_m_valid
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && (!r_m_valid || m_axis_tready)) begin
            r_m_tuser <= {r_closed, r_status};
            r_m_tdata <= {r_o_rate, MS_W'(r_o_time), ITEMS_W'(r_o_cnt),
                          r_lw_rate, MS_W'(r_lw_time), ITEMS_W'(r_lw_cnt),
                          IDX_W'(r_lw_idx)};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    wtm_div #(
        .DVW (DVW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_dvd),
        .i_divisor   (r_dvs),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // divider is never restarted mid-division
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !div_busy)
        else $error("divider started while busy");

    // nothing left in the divider once the sequencer is back at idle
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!div_busy && !r_div_start))
        else $error("divider active while idle");

    // an ignored report never closes a window
    a_ignored_not_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("ignored report flagged as closing a window");

    // an accepted command is executed on the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_EXEC))
        else $error("accepted command not executed");

endmodule
`default_nettype wire
